// ===== rtl/tbsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsw_pkg: shared types, constants and helpers of the three-band width stage
// Fixed-point widths, register codes and saturation functions used by the
// interfaces, the configuration registers, the digit multiplier and the core.
// ----------------------------------------------------------------------------
package tbsw_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int INTEG_W    = 32;
  localparam int FILT_W     = INTEG_W + 8;
  localparam int GAIN_W     = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int PP_W       = FILT_W + DIGIT_W + 1;
  localparam int PROD_W     = FILT_W + GAIN_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int WIDTH_FRAC = 14;
  localparam int OUT_SHIFT  = WIDTH_FRAC + 1;
  localparam int OSH_W      = ACC_W - OUT_SHIFT;
  localparam int NUM_LANES  = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = GAIN_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [INTEG_W-1:0]  integ_t;
  typedef logic signed [FILT_W-1:0]   filt_t;
  typedef logic signed [FILT_W:0]     wide_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OSH_W-1:0]    osh_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_SPLIT_GAIN  = CFG_IDX_W'(0),
    CFG_HIGH_SPLIT_GAIN = CFG_IDX_W'(1),
    CFG_MID_WIDTH       = CFG_IDX_W'(2),
    CFG_HIGH_WIDTH      = CFG_IDX_W'(3)
  } cfg_reg_e;

  // Register reset values and limits
  localparam gain_t LOW_GAIN_RST   = GAIN_W'(553);
  localparam gain_t HIGH_GAIN_RST  = GAIN_W'(9608);
  localparam gain_t WIDTH_UNITY    = gain_t'(1) << WIDTH_FRAC;
  localparam gain_t WIDTH_MAX      = gain_t'(1) << (WIDTH_FRAC + 1);

  // Rounding offsets
  localparam prod_t V_RND   = prod_t'(1) <<< (GAIN_W - 1);
  localparam acc_t  OUT_RND = acc_t'(1) <<< WIDTH_FRAC;

  // Saturation bounds in the wider working formats
  localparam wide_t INTEG_MAX_W = {{(FILT_W - INTEG_W + 2){1'b0}}, {(INTEG_W - 1){1'b1}}};
  localparam wide_t INTEG_MIN_W = ~INTEG_MAX_W;
  localparam osh_t  SMP_MAX_W   = {{(OSH_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam osh_t  SMP_MIN_W   = ~SMP_MAX_W;

  // Configuration as seen by the core, widths already limited to two
  typedef struct packed {
    gain_t low_gain;
    gain_t high_gain;
    gain_t mid_width;
    gain_t high_width;
  } cfg_t;

  // Multiplier request and response
  typedef struct packed {
    logic  start;
    filt_t mcand;
    gain_t mplier;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    prod_t product;
  } mul_rsp_t;

  // Clamp an integrator update to the signed 32-bit range
  function automatic integ_t sat_integ(input wide_t val);
    integ_t res;
    if (val > INTEG_MAX_W) begin
      res = {1'b0, {(INTEG_W - 1){1'b1}}};
    end else if (val < INTEG_MIN_W) begin
      res = {1'b1, {(INTEG_W - 1){1'b0}}};
    end else begin
      res = val[INTEG_W-1:0];
    end
    return res;
  endfunction

  // Clamp a rescaled output to the sample range
  function automatic sample_t sat_sample(input osh_t val);
    sample_t res;
    if (val > SMP_MAX_W) begin
      res = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (val < SMP_MIN_W) begin
      res = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      res = val[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/tbsw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsw_if: stream and configuration channels of the three-band width stage
// Sample input, sample output and register write channels, each with a
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface tbsw_in_if;
  import tbsw_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  logic    block_last_in;

  modport source (output valid, left_in, right_in, block_last_in, input ready);
  modport sink   (input valid, left_in, right_in, block_last_in, output ready);
endinterface

interface tbsw_out_if;
  import tbsw_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  logic    block_last_out;

  modport source (output valid, left_out, right_out, block_last_out, input ready);
  modport sink   (input valid, left_out, right_out, block_last_out, output ready);
endinterface

interface tbsw_cfg_if;
  import tbsw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tbsw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsw_cfg_regs: configuration registers
// Holds the two crossover gains and the two band widths; widths above two
// are limited on the way out.
// ----------------------------------------------------------------------------
module tbsw_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  tbsw_cfg_if.sink         cfg_i,
  output tbsw_pkg::cfg_t   cfg_o
);
  import tbsw_pkg::*;

  gain_t low_gain_q;
  gain_t high_gain_q;
  gain_t mid_width_q;
  gain_t high_width_q;

  // Always take a write transaction
  assign cfg_i.ready = 1'b1;

  // Update the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_gain_q   <= LOW_GAIN_RST;
      high_gain_q  <= HIGH_GAIN_RST;
      mid_width_q  <= WIDTH_UNITY;
      high_width_q <= WIDTH_UNITY;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_LOW_SPLIT_GAIN:  low_gain_q   <= cfg_i.data;
        CFG_HIGH_SPLIT_GAIN: high_gain_q  <= cfg_i.data;
        CFG_MID_WIDTH:       mid_width_q  <= cfg_i.data;
        CFG_HIGH_WIDTH:      high_width_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Limit widths to two
  always_comb begin
    cfg_o.low_gain   = low_gain_q;
    cfg_o.high_gain  = high_gain_q;
    cfg_o.mid_width  = (mid_width_q > WIDTH_MAX) ? WIDTH_MAX : mid_width_q;
    cfg_o.high_width = (high_width_q > WIDTH_MAX) ? WIDTH_MAX : high_width_q;
  end

endmodule

// ===== rtl/tbsw_digit_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsw_digit_mul: digit-serial signed by unsigned multiplier
// Consumes the unsigned multiplier one 4-bit digit per cycle, most
// significant digit first, accumulating shifted partial products.
// ----------------------------------------------------------------------------
module tbsw_digit_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbsw_pkg::mul_req_t req_i,
  output tbsw_pkg::mul_rsp_t rsp_o
);
  import tbsw_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DIG_CNT_W-1:0]   cnt_q, cnt_d;
  filt_t                  mcand_q, mcand_d;
  gain_t                  mplier_q, mplier_d;
  prod_t                  acc_q, acc_d;
  logic [DIGIT_W-1:0]     digit;
  logic signed [PP_W-1:0] pp;

  // Partial product of the current top digit
  assign digit = mplier_q[GAIN_W-1 -: DIGIT_W];
  assign pp    = PP_W'(mcand_q) * PP_W'($signed({1'b0, digit}));

  // Load on start, then shift and accumulate one digit per cycle
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = DIG_CNT_W'(NUM_DIGITS);
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      acc_d    = '0;
    end else if (busy_q) begin
      acc_d    = (acc_q <<< DIGIT_W) + {{(PROD_W - PP_W){pp[PP_W-1]}}, pp};
      mplier_d = mplier_q << DIGIT_W;
      cnt_d    = cnt_q - DIG_CNT_W'(1);
      if (cnt_q == DIG_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

// ===== rtl/three_band_stereo_width_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_band_stereo_width_core: three-band mid/side stereo width stage
// Splits each channel with two cascaded one-pole TPT lowpasses, folds the
// low band to mono, scales the side signal of the mid and high bands and
// recombines to a saturated stereo pair.
// ----------------------------------------------------------------------------
// One stereo pair is processed at a time; a new pair is accepted only in
// the idle state. Two digit-serial multipliers, one per channel in the
// crossover passes, take a 16-bit gain or width four bits per cycle in
// each of the three multiply passes (low crossover, high crossover, side
// scaling), and the add, update and saturate steps sit between them. The
// result is held in an output register, so the next pair is taken while
// it waits.
// Register writes are always ready; write them only while the block is idle.
// There is no clearing pass: the four integrators reset to zero at once.
module three_band_stereo_width_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbsw_in_if.sink     sample_i,
  tbsw_out_if.source  sample_o,
  tbsw_cfg_if.sink    cfg_i
);
  import tbsw_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_LOW_GO   = 12'b000000000010,
    ST_LOW_MUL  = 12'b000000000100,
    ST_LOW_UPD  = 12'b000000001000,
    ST_REST     = 12'b000000010000,
    ST_MID_GO   = 12'b000000100000,
    ST_MID_MUL  = 12'b000001000000,
    ST_MID_UPD  = 12'b000010000000,
    ST_HI       = 12'b000100000000,
    ST_SIDE_GO  = 12'b001000000000,
    ST_SIDE_MUL = 12'b010000000000,
    ST_OUT      = 12'b100000000000
  } state_e;

  state_e   state_q, state_d;
  cfg_t     cfg;
  mul_req_t mul_req [NUM_LANES];
  mul_rsp_t mul_rsp [NUM_LANES];

  sample_t  in_smp   [NUM_LANES];
  sample_t  x_q      [NUM_LANES];
  integ_t   s_low_q  [NUM_LANES];
  integ_t   s_mid_q  [NUM_LANES];
  filt_t    v_q      [NUM_LANES];
  filt_t    band_q   [NUM_LANES];
  filt_t    rest_q   [NUM_LANES];
  filt_t    hi_q     [NUM_LANES];
  filt_t    side_mc  [NUM_LANES];
  gain_t    side_mp  [NUM_LANES];

  logic     last_q;
  acc_t     base_q;
  acc_t     side_q;
  acc_t     sum_l, sum_r;
  logic     in_fire;
  logic     out_free;
  logic     out_load;
  logic     out_valid_q;
  sample_t  left_q, right_q;
  logic     out_last_q;

  tbsw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || sample_o.ready;
  assign out_load = (state_q == ST_OUT) && out_free;

  assign sample_i.ready = (state_q == ST_IDLE);

  assign in_smp[0] = sample_i.left_in;
  assign in_smp[1] = sample_i.right_in;

  // Side operands: mid band difference on one lane, high band on the other
  assign side_mc[0] = band_q[0] - band_q[1];
  assign side_mc[1] = hi_q[0] - hi_q[1];
  assign side_mp[0] = cfg.mid_width;
  assign side_mp[1] = cfg.high_width;

  // Sequence one pair through the three multiply passes
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_LOW_GO;
      ST_LOW_GO:   state_d = ST_LOW_MUL;
      ST_LOW_MUL:  if (mul_rsp[0].done) state_d = ST_LOW_UPD;
      ST_LOW_UPD:  state_d = ST_REST;
      ST_REST:     state_d = ST_MID_GO;
      ST_MID_GO:   state_d = ST_MID_MUL;
      ST_MID_MUL:  if (mul_rsp[0].done) state_d = ST_MID_UPD;
      ST_MID_UPD:  state_d = ST_HI;
      ST_HI:       state_d = ST_SIDE_GO;
      ST_SIDE_GO:  state_d = ST_SIDE_MUL;
      ST_SIDE_MUL: if (mul_rsp[0].done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-channel filter lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    integ_t s_sel;
    filt_t  s_ext;
    prod_t  v_sum;
    filt_t  v_new;
    filt_t  y_new;
    wide_t  s_sum;
    integ_t s_new;

    tbsw_digit_mul u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (mul_req[l]),
      .rsp_o  (mul_rsp[l])
    );

    // Pick the operands of the current pass
    always_comb begin
      mul_req[l].start = (state_q == ST_LOW_GO) || (state_q == ST_MID_GO) ||
                         (state_q == ST_SIDE_GO);
      priority if (state_q == ST_LOW_GO) begin
        mul_req[l].mcand  = FILT_W'(x_q[l]) - FILT_W'(s_low_q[l]);
        mul_req[l].mplier = cfg.low_gain;
      end else if (state_q == ST_MID_GO) begin
        mul_req[l].mcand  = rest_q[l] - FILT_W'(s_mid_q[l]);
        mul_req[l].mplier = cfg.high_gain;
      end else begin
        mul_req[l].mcand  = side_mc[l];
        mul_req[l].mplier = side_mp[l];
      end
    end

    // Round the product, form the band output and the integrator update
    always_comb begin
      s_sel = (state_q == ST_MID_UPD) ? s_mid_q[l] : s_low_q[l];
      s_ext = FILT_W'(s_sel);
      v_sum = mul_rsp[l].product + V_RND;
      v_new = $signed(v_sum[PROD_W-1 -: FILT_W]);
      y_new = v_q[l] + s_ext;
      s_sum = (FILT_W + 1)'(s_ext) + $signed({v_q[l], 1'b0});
      s_new = sat_integ(s_sum);
    end

    // Integrators
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_low_q[l] <= '0;
        s_mid_q[l] <= '0;
      end else begin
        if (state_q == ST_LOW_UPD) s_low_q[l] <= s_new;
        if (state_q == ST_MID_UPD) s_mid_q[l] <= s_new;
      end
    end

    // Lane data
    always_ff @(posedge clk_i) begin
      if (in_fire) x_q[l] <= in_smp[l];
      if (((state_q == ST_LOW_MUL) || (state_q == ST_MID_MUL)) && mul_rsp[l].done) begin
        v_q[l] <= v_new;
      end
      if ((state_q == ST_LOW_UPD) || (state_q == ST_MID_UPD)) band_q[l] <= y_new;
      if (state_q == ST_REST) rest_q[l] <= FILT_W'(x_q[l]) - band_q[l];
      if (state_q == ST_HI) hi_q[l] <= rest_q[l] - band_q[l];
    end
  end

  // Recombine: the three bands of a channel sum back to its input
  assign sum_l = base_q + side_q;
  assign sum_r = base_q - side_q;

  // Shared terms and the block end mark
  always_ff @(posedge clk_i) begin
    if (in_fire) last_q <= sample_i.block_last_in;
    if (state_q == ST_REST) begin
      base_q <= ((ACC_W'(x_q[0]) + ACC_W'(x_q[1])) <<< WIDTH_FRAC) + OUT_RND;
    end
    if ((state_q == ST_SIDE_MUL) && mul_rsp[0].done) begin
      side_q <= ACC_W'(mul_rsp[0].product) + ACC_W'(mul_rsp[1].product);
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (sample_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q     <= sat_sample($signed(sum_l[ACC_W-1:OUT_SHIFT]));
      right_q    <= sat_sample($signed(sum_r[ACC_W-1:OUT_SHIFT]));
      out_last_q <= last_q;
    end
  end

  assign sample_o.valid          = out_valid_q;
  assign sample_o.left_out       = left_q;
  assign sample_o.right_out      = right_q;
  assign sample_o.block_last_out = out_last_q;

endmodule
